FILE: rtl/cnh_pkg.sv
// Shared types and constants for the Canny thinning and edge tracking block.
// No dependencies; most other files import this package.
package cnh_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int MAG_W     = 16;
    localparam int DIR_W     = 2;
    localparam int SIZE_W    = 12;   // width and height registers
    localparam int CFG_W     = 16;   // widest register
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W     = 13;   // row counter, carries ROW_OFS
    localparam int ROW_OFS   = 4;    // row k is held as k + ROW_OFS so look-behind stays positive
    localparam int Q_DEPTH   = 4;
    localparam int OUT_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd3;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [DIR_W-1:0] DIR_H   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_V   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

    localparam logic [MAG_W-1:0] RST_LOW  = 16'd0;
    localparam logic [MAG_W-1:0] RST_HIGH = 16'hFFFF;
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 12'd480;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [MAG_W-1:0]  magnitude;
        logic [DIR_W-1:0]  direction;
    } entry_t;

endpackage

FILE: rtl/cnh_ifs.sv
// Stream channel interfaces for the input items and the results.
// Depends on cnh_pkg.
interface cnh_in_if;
    import cnh_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [MAG_W-1:0]    magnitude;
    logic [DIR_W-1:0]    direction;

    modport source (output valid, output func, output magnitude, output direction, input ready);
    modport sink   (input valid, input func, input magnitude, input direction, output ready);
endinterface

interface cnh_out_if;
    import cnh_pkg::*;
    logic                valid;
    logic                ready;
    logic [MAG_W-1:0]    edge_value;
    logic                frame_last;

    modport source (output valid, output edge_value, output frame_last, input ready);
    modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

FILE: rtl/cnh_queue.sv
// Short request queue between the front and the back end.
// Depends on cnh_pkg.
module cnh_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cnh_pkg::entry_t push_entry,
    input  logic            pop,
    output cnh_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import cnh_pkg::*;

    localparam int QA = $clog2(Q_DEPTH);

    entry_t          slot_reg [Q_DEPTH];
    logic [QA-1:0]   wp_reg, rp_reg;
    logic [QA:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QA+1)'(Q_DEPTH));
    assign head  = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_entry;
    end

endmodule

FILE: rtl/cnh_line_mem.sv
// One-row line memory, one write and one read port, registered read,
// write-first on a same-address collision. No dependencies.
module cnh_line_mem
#(
    parameter int DEPTH = 2048,
    parameter int DW    = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (we && waddr == raddr)
            rdata_reg <= wdata;
        else
            rdata_reg <= mem[raddr];
    end

endmodule

FILE: rtl/cnh_front.sv
// Front end: takes items, tracks the raster position of the frame and turns
// pixels and drain ticks into queue requests. Depends on cnh_pkg, cnh_ifs.
module cnh_front
#(
    parameter int MAX_WIDTH = cnh_pkg::MAX_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    cnh_in_if.sink                               in_ch,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       width,
    input  logic [cnh_pkg::SIZE_W-1:0]           height,
    input  logic                                 full,
    output logic                                 push,
    output cnh_pkg::entry_t                      push_entry
);
    import cnh_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = WW + 2;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [SIZE_W-1:0] row_reg, row_next;
    logic [PW-1:0]     left_reg, left_next;
    logic [PW-1:0]     pend;
    logic              accept, last_col, last_row;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign last_col    = (WW'(col_reg) == width - WW'(1));
    assign last_row    = (row_reg == height - SIZE_W'(1));

    // results still owed once the last pixel is in: min(W*H, 2W+2)
    always_comb
    begin
        if (height == SIZE_W'(1))
            pend = PW'(width);
        else if (height == SIZE_W'(2))
            pend = PW'({width, 1'b0});
        else if (height == SIZE_W'(3) && width == WW'(1))
            pend = PW'(3);
        else
            pend = PW'({width, 1'b0}) + PW'(2);
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        push       = 1'b0;
        push_entry.kind      = KIND_PIXEL;
        push_entry.magnitude = in_ch.magnitude;
        push_entry.direction = in_ch.direction;
        case (state_reg)
            ST_FILL:
            begin
                if (accept && in_ch.func == FUNC_PIXEL)
                begin
                    push = 1'b1;
                    if (last_col)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            row_next   = '0;
                            left_next  = pend;
                            state_next = ST_DRAIN;
                        end
                        else
                            row_next = row_reg + 1'b1;
                    end
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                push_entry.kind      = KIND_DRAIN;
                push_entry.magnitude = '0;
                push_entry.direction = '0;
                if (accept)
                begin
                    push      = 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == PW'(1))
                        state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: rtl/cnh_back.sv
// Back end: raster slot sequencer, 3x3 thinning over magnitude lines,
// 3x3 hysteresis over thinned lines, result buffer.
// Depends on cnh_pkg, cnh_ifs, cnh_line_mem.
module cnh_back
#(
    parameter int MAX_WIDTH = cnh_pkg::MAX_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
    input  logic [cnh_pkg::SIZE_W-1:0]     height,
    input  logic [cnh_pkg::MAG_W-1:0]      low_level,
    input  logic [cnh_pkg::MAG_W-1:0]      high_level,
    input  cnh_pkg::entry_t                head,
    input  logic                           empty,
    output logic                           pop,
    cnh_out_if.source                      out_ch
);
    import cnh_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH+1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int OA  = $clog2(OUT_DEPTH);
    localparam int LMW = 2*MAG_W + DIR_W;
    localparam int SMW = 2*MAG_W;

    // slot sequencer
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WW-1:0]    wm1;
    logic [ROW_W-1:0] row_first, row_last, row_end;
    logic [CW-1:0]    qc, hc;
    logic [ROW_W-1:0] qr, hr;
    logic             emit, flast, issue, credit_ok;

    // pipeline
    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic             s1_e_reg, s2_e_reg, s3_e_reg, s4_e_reg;
    logic             s1_l_reg, s2_l_reg, s3_l_reg, s4_l_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    logic [DIR_W-1:0] s1_dir_reg;
    logic [CW-1:0]    s1_c_reg, s1_qc_reg, s2_qc_reg, s3_qc_reg;
    logic [ROW_W-1:0] s1_qr_reg, s2_qr_reg;
    logic [CW-1:0]    s1_hc_reg, s2_hc_reg, s3_hc_reg, s4_hc_reg;
    logic [ROW_W-1:0] s1_hr_reg, s2_hr_reg, s3_hr_reg, s4_hr_reg;
    logic [MAG_W-1:0] s3_val_reg;

    logic [LMW-1:0]   lm_rd, lm_wd;
    logic [SMW-1:0]   sm_rd, sm_wd;
    logic [MAG_W-1:0] mw_reg [3][3];
    logic [MAG_W-1:0] sw_reg [3][3];
    logic [DIR_W-1:0] dnew_reg, dcen_reg;

    logic [MAG_W-1:0] mk [3][3];
    logic [MAG_W-1:0] sk [3][3];
    logic [MAG_W-1:0] nb_a, nb_b, thin_val, edge_val;
    logic             q_top, q_bot, q_left, q_right;
    logic             h_top, h_bot, h_left, h_right, strong_nb;

    // result buffer
    logic [MAG_W-1:0] ov_reg [OUT_DEPTH];
    logic             ol_reg [OUT_DEPTH];
    logic [OA-1:0]    owp_reg, orp_reg;
    logic [OA:0]      ocnt_reg;
    logic             opush, opop;

    assign wm1       = width - WW'(1);
    assign row_first = ROW_W'(ROW_OFS);
    assign row_end   = ROW_W'(height) + ROW_W'(ROW_OFS);
    assign row_last  = row_end - ROW_W'(1);

    // position one line plus one pixel back, applied twice
    always_comb
    begin
        qc = (col_reg == '0) ? CW'(wm1) : col_reg - 1'b1;
        qr = (col_reg == '0) ? row_reg - ROW_W'(2) : row_reg - ROW_W'(1);
        hc = (qc == '0) ? CW'(wm1) : qc - 1'b1;
        hr = (qc == '0) ? qr - ROW_W'(2) : qr - ROW_W'(1);
    end

    assign emit  = (hr >= row_first) && (hr < row_end);
    assign flast = emit && (hr == row_last) && (WW'(hc) == wm1);

    // room in the result buffer for everything already in flight
    assign credit_ok = ((OA+2)'(ocnt_reg) + (OA+2)'(s1_e_reg) + (OA+2)'(s2_e_reg)
                        + (OA+2)'(s3_e_reg) + (OA+2)'(s4_e_reg)) < (OA+2)'(OUT_DEPTH);
    assign issue = !empty && credit_ok;
    assign pop   = issue && (head.kind == KIND_PIXEL || emit);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (issue)
        begin
            if (flast)
            begin
                col_next = '0;
                row_next = row_first;
            end
            else if (WW'(col_reg) == wm1)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
                col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= ROW_W'(ROW_OFS);
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s1_e_reg <= 1'b0;
            s2_e_reg <= 1'b0;
            s3_e_reg <= 1'b0;
            s4_e_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            s1_v_reg <= issue;
            s1_e_reg <= issue && emit;
            s2_v_reg <= s1_v_reg;
            s2_e_reg <= s1_e_reg;
            s3_v_reg <= s2_v_reg;
            s3_e_reg <= s2_e_reg;
            s4_v_reg <= s3_v_reg;
            s4_e_reg <= s3_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg <= (head.kind == KIND_PIXEL) ? head.magnitude : '0;
        s1_dir_reg <= (head.kind == KIND_PIXEL) ? head.direction : '0;
        s1_c_reg   <= col_reg;
        s1_qc_reg  <= qc;
        s1_qr_reg  <= qr;
        s1_hc_reg  <= hc;
        s1_hr_reg  <= hr;
        s1_l_reg   <= flast;
        s2_qc_reg  <= s1_qc_reg;
        s2_qr_reg  <= s1_qr_reg;
        s2_hc_reg  <= s1_hc_reg;
        s2_hr_reg  <= s1_hr_reg;
        s2_l_reg   <= s1_l_reg;
        s3_qc_reg  <= s2_qc_reg;
        s3_hc_reg  <= s2_hc_reg;
        s3_hr_reg  <= s2_hr_reg;
        s3_l_reg   <= s2_l_reg;
        s3_val_reg <= thin_val;
        s4_hc_reg  <= s3_hc_reg;
        s4_hr_reg  <= s3_hr_reg;
        s4_l_reg   <= s3_l_reg;
    end

    // magnitude lines: {row-1 magnitude, row-2 magnitude, row-1 direction}
    assign lm_wd = {s1_mag_reg, lm_rd[LMW-1 -: MAG_W], s1_dir_reg};

    cnh_line_mem #(.DEPTH(MAX_WIDTH), .DW(LMW)) u_mag_lines
    (
        .clk   (clk),
        .we    (s1_v_reg),
        .waddr (s1_c_reg),
        .wdata (lm_wd),
        .raddr (col_reg),
        .rdata (lm_rd)
    );

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mw_reg[i][0] <= mw_reg[i][1];
                mw_reg[i][1] <= mw_reg[i][2];
            end
            mw_reg[0][2] <= lm_rd[DIR_W +: MAG_W];
            mw_reg[1][2] <= lm_rd[LMW-1 -: MAG_W];
            mw_reg[2][2] <= s1_mag_reg;
            dnew_reg     <= lm_rd[DIR_W-1:0];
            dcen_reg     <= dnew_reg;
        end
    end

    // thinning; neighbours outside the frame read as zero
    assign q_top   = (s2_qr_reg == row_first);
    assign q_bot   = (s2_qr_reg == row_last);
    assign q_left  = (s2_qc_reg == '0);
    assign q_right = (WW'(s2_qc_reg) == wm1);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((i == 0 && q_top) || (i == 2 && q_bot) || (j == 0 && q_left)
                    || (j == 2 && q_right))
                    mk[i][j] = '0;
                else
                    mk[i][j] = mw_reg[i][j];
            end
        end
    end

    always_comb
    begin
        case (dcen_reg)
            DIR_H:
            begin
                nb_a = mk[1][2];
                nb_b = mk[1][0];
            end
            DIR_45:
            begin
                nb_a = mk[0][2];
                nb_b = mk[2][0];
            end
            DIR_V:
            begin
                nb_a = mk[0][1];
                nb_b = mk[2][1];
            end
            DIR_135:
            begin
                nb_a = mk[0][0];
                nb_b = mk[2][2];
            end
            default:
            begin
                nb_a = '0;
                nb_b = '0;
            end
        endcase
        if (mw_reg[1][1] > nb_a && mw_reg[1][1] > nb_b && mw_reg[1][1] >= low_level)
            thin_val = mw_reg[1][1];
        else
            thin_val = '0;
    end

    // thinned lines: {row-1, row-2}
    assign sm_wd = {s3_val_reg, sm_rd[SMW-1 -: MAG_W]};

    cnh_line_mem #(.DEPTH(MAX_WIDTH), .DW(SMW)) u_thin_lines
    (
        .clk   (clk),
        .we    (s3_v_reg),
        .waddr (s3_qc_reg),
        .wdata (sm_wd),
        .raddr (s2_qc_reg),
        .rdata (sm_rd)
    );

    always_ff @(posedge clk)
    begin
        if (s3_v_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sw_reg[i][0] <= sw_reg[i][1];
                sw_reg[i][1] <= sw_reg[i][2];
            end
            sw_reg[0][2] <= sm_rd[MAG_W-1:0];
            sw_reg[1][2] <= sm_rd[SMW-1 -: MAG_W];
            sw_reg[2][2] <= s3_val_reg;
        end
    end

    // single-pass hysteresis
    assign h_top   = (s4_hr_reg == row_first);
    assign h_bot   = (s4_hr_reg == row_last);
    assign h_left  = (s4_hc_reg == '0);
    assign h_right = (WW'(s4_hc_reg) == wm1);

    always_comb
    begin
        strong_nb = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((i == 0 && h_top) || (i == 2 && h_bot) || (j == 0 && h_left)
                    || (j == 2 && h_right) || (i == 1 && j == 1))
                    sk[i][j] = '0;
                else
                    sk[i][j] = sw_reg[i][j];
                if (sk[i][j] > high_level)
                    strong_nb = 1'b1;
            end
        end
        edge_val = (sw_reg[1][1] >= high_level || strong_nb) ? sw_reg[1][1] : '0;
    end

    assign opush = s4_v_reg && s4_e_reg;
    assign opop  = out_ch.valid && out_ch.ready;

    assign out_ch.valid      = (ocnt_reg != '0);
    assign out_ch.edge_value = ov_reg[orp_reg];
    assign out_ch.frame_last = ol_reg[orp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (opush)
                owp_reg <= owp_reg + 1'b1;
            if (opop)
                orp_reg <= orp_reg + 1'b1;
            if (opush && !opop)
                ocnt_reg <= ocnt_reg + 1'b1;
            else if (opop && !opush)
                ocnt_reg <= ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            ov_reg[owp_reg] <= edge_val;
            ol_reg[owp_reg] <= s4_l_reg;
        end
    end

endmodule

FILE: rtl/canny_nms_hysteresis_top.sv
// Top level of the Canny thinning and edge tracking block: configuration
// registers, front end, request queue, back end. Depends on cnh_pkg, cnh_ifs,
// cnh_front, cnh_queue, cnh_back.
//
//   port     dir   handshake     payload
//   in_ch    in    valid/ready   func, magnitude, direction
//   out_ch   out   valid/ready   edge_value, frame_last
//   cfg_*    in    cfg_we only   cfg_index, cfg_data
//
// One item per clock sustained while out_ch is not stalled; a result is offered
// once its slot has passed the s1 to s4 registers and the result buffer,
// and a pixel's result comes from the slot 2W+2 slots after its own.
// The back end issues one raster slot per clock while the queue holds a request
// and the result buffer has room; a drain request on a frame smaller than two
// lines may take up to 2W+2 slots. Reset is asynchronous and needs no clearing
// pass: border masking hides stale line contents. A stalled output fills the
// 8-deep result buffer, then the 4-deep queue, then drops in_ch.ready.
module canny_nms_hysteresis_top
#(
    parameter int MAX_WIDTH = cnh_pkg::MAX_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    cnh_in_if.sink                            in_ch,
    cnh_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [cnh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cnh_pkg::CFG_W-1:0]         cfg_data
);
    import cnh_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH+1);

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [MAG_W-1:0]  low_reg, high_reg;
    logic [WW-1:0]     eff_width;
    logic [SIZE_W-1:0] eff_height;
    logic              push, pop, q_empty, q_full;
    entry_t            push_entry, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            low_reg    <= RST_LOW;
            high_reg   <= RST_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_LOW:    low_reg    <= cfg_data;
                CFG_HIGH:   high_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // zero size reads as one, width clamps to the line memory depth
    always_comb
    begin
        if (width_reg == '0)
            eff_width = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_reg);
        eff_height = (height_reg == '0) ? SIZE_W'(1) : height_reg;
    end

    cnh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .width      (eff_width),
        .height     (eff_height),
        .full       (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cnh_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    cnh_back #(.MAX_WIDTH(MAX_WIDTH)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .width      (eff_width),
        .height     (eff_height),
        .low_level  (low_reg),
        .high_level (high_reg),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

FILE: rtl/cnh_checker.sv
// Port-level checks for the top level, attached by bind.
// Depends on cnh_ifs and canny_nms_hysteresis_top.
module cnh_checker
(
    input logic        clk,
    input logic        rst_n,
    cnh_in_if.sink     in_ch,
    cnh_out_if.source  out_ch
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.edge_value)
                                          && $stable(out_ch.frame_last))
        else $error("result payload changed while stalled");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_ch.valid)
        else $error("result offered straight out of reset");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ch.ready)
        else $error("input not ready straight out of reset");

endmodule

bind canny_nms_hysteresis_top cnh_checker u_cnh_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);

FILE: tb/canny_nms_hysteresis_top_tb.sv
// Testbench for canny_nms_hysteresis_top: a directed table, then random frames with
// random sizes and thresholds, all checked against a behavioural model of the block.
// Depends on cnh_pkg, cnh_ifs and the block's RTL.
module canny_nms_hysteresis_top_tb;
    import cnh_pkg::*;

    localparam int RING     = 2 * MAX_WIDTH_DEF + 4;
    localparam int OP_PIX   = 0;
    localparam int OP_FLUSH = 1;
    localparam int OP_CFG   = 2;
    localparam int WD_LIMIT = 20000;
    localparam int HOLD_LEN = 300;

    typedef struct {
        logic [MAG_W-1:0] val;
        logic             last;
    } edge_res_t;

    typedef struct {
        int               op;
        int               a;      // magnitude or register index
        int               b;      // direction or register data
        bit               chk;
        logic [MAG_W-1:0] ev;
        logic             el;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    cnh_in_if  in_ch();
    cnh_out_if out_ch();

    canny_nms_hysteresis_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // behavioural model state
    logic [MAG_W-1:0] mag_ring [RING];
    logic [DIR_W-1:0] dir_ring [RING];
    logic [MAG_W-1:0] thin_ring [RING];
    int unsigned col_pos, row_pos, pend_cnt, fw, fh;
    int unsigned reg_w, reg_h, reg_low, reg_high;
    edge_res_t edge_q[$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_frames = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int quiet = 0;

    // offsets along each direction: dr1, dc1, dr2, dc2
    int along [4][4] = '{'{0, 1, 0, -1}, '{-1, 1, 1, -1}, '{-1, 0, 1, 0}, '{-1, -1, 1, 1}};

    stim_row_t dir_tab [25] = '{
        '{OP_CFG, CFG_WIDTH, 0, 0, 0, 0},
        '{OP_CFG, CFG_HEIGHT, 0, 0, 0, 0},
        '{OP_CFG, CFG_LOW, 0, 0, 0, 0},
        '{OP_CFG, CFG_HIGH, 0, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0},
        '{OP_PIX, 16'hFFFF, DIR_H, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 1, 16'hFFFF, 1},
        '{OP_PIX, 0, DIR_135, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 1, 16'h0000, 1},
        '{OP_CFG, CFG_WIDTH, 3, 0, 0, 0},
        '{OP_CFG, CFG_HEIGHT, 2, 0, 0, 0},
        '{OP_CFG, CFG_LOW, 16, 0, 0, 0},
        '{OP_PIX, 40, DIR_H, 0, 0, 0},
        '{OP_PIX, 80, DIR_V, 0, 0, 0},
        '{OP_PIX, 20, DIR_45, 0, 0, 0},
        '{OP_PIX, 60, DIR_135, 0, 0, 0},
        '{OP_PIX, 10, DIR_H, 0, 0, 0},
        '{OP_PIX, 16'hFFFF, DIR_45, 0, 0, 0},
        '{OP_PIX, 16'h1234, DIR_V, 0, 0, 0},   // lands while draining
        '{OP_FLUSH, 0, 0, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0}
    };

    function automatic int unsigned ring_at(bit thinned, int r, int c);
        int unsigned s;
        if (r < 0 || r >= int'(fh) || c < 0 || c >= int'(fw))
            return 0;
        s = (r * fw + c) % RING;
        return thinned ? thin_ring[s] : mag_ring[s];
    endfunction

    function automatic void thin_at(int unsigned q);
        int r, c;
        int unsigned s, m, na, nb, v;
        int d;
        r = q / fw;
        c = q % fw;
        s = q % RING;
        m = mag_ring[s];
        d = dir_ring[s];
        na = ring_at(0, r + along[d][0], c + along[d][1]);
        nb = ring_at(0, r + along[d][2], c + along[d][3]);
        v = (m > na && m > nb) ? m : 0;
        if (v < reg_low)
            v = 0;
        thin_ring[s] = v[MAG_W-1:0];
    endfunction

    function automatic int unsigned track_at(int unsigned h);
        int r, c;
        int unsigned v;
        r = h / fw;
        c = h % fw;
        v = thin_ring[h % RING];
        if (v >= reg_high)
            return v;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if ((dr != 0 || dc != 0) && ring_at(1, r + dr, c + dc) > reg_high)
                    return v;
        return 0;
    endfunction

    // one raster slot; pushes a result when the slot yields one
    function automatic bit raster_slot();
        int unsigned t, n, span, h;
        bit got, last;
        edge_res_t res;
        t = row_pos * fw + col_pos;
        n = fw * fh;
        span = fw + 1;
        got = 0;
        last = 0;
        if (t >= span && t - span < n)
            thin_at(t - span);
        if (t >= 2 * span && t - 2 * span < n) begin
            h = t - 2 * span;
            last = (h == n - 1);
            res.val = MAG_W'(track_at(h));
            res.last = last;
            edge_q.push_back(res);
            if (pend_cnt > 0)
                pend_cnt--;
            got = 1;
        end
        col_pos++;
        if (col_pos >= fw) begin
            col_pos = 0;
            row_pos++;
        end
        if (last) begin
            col_pos = 0;
            row_pos = 0;
            pend_cnt = 0;
        end
        return got;
    endfunction

    function automatic bit edge_predict(logic f, logic [MAG_W-1:0] m, logic [DIR_W-1:0] d);
        int unsigned t, s;
        if (row_pos == 0 && col_pos == 0) begin
            if (f == FUNC_FLUSH)
                return 0;
            fw = (reg_w == 0) ? 1 : (reg_w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : reg_w);
            fh = (reg_h == 0) ? 1 : reg_h;
        end
        t = row_pos * fw + col_pos;
        if (t < fw * fh) begin
            if (f == FUNC_FLUSH)
                return 0;
            s = t % RING;
            mag_ring[s] = m;
            dir_ring[s] = d;
            pend_cnt++;
            return raster_slot();
        end
        for (int i = 0; i <= 2 * int'(fw) + 3; i++)
            if (raster_slot())
                return 1;
        return 0;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %0s: got %0d, expected %0d (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    // sender stops offering and waits until every expected result is back
    task automatic wait_quiet();
        int settle;
        settle = 20;
        in_ch.valid <= 1'b0;
        while (edge_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(int idx, int data);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= data[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx[CFG_IDX_W-1:0])
            CFG_WIDTH:  reg_w = data & 12'hFFF;
            CFG_HEIGHT: reg_h = data & 12'hFFF;
            CFG_LOW:    reg_low = data & 16'hFFFF;
            default:    reg_high = data & 16'hFFFF;
        endcase
    endtask

    // drives one request and returns whether the model expects a result from it;
    // valid stays high afterwards so the next request can follow at once
    task automatic send_req(logic f, logic [MAG_W-1:0] m, logic [DIR_W-1:0] d,
                            output bit got);
        if (gaps_on && $urandom_range(0, 99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 40)
                @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.magnitude <= m;
        in_ch.direction <= d;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        got = edge_predict(f, m, d);
        n_items++;
    endtask

    function automatic logic [MAG_W-1:0] rand_mag();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5)
            return 16'hFFFF;
        if (k < 10)
            return 16'h0000;
        if (k < 25)
            return MAG_W'($urandom());
        return MAG_W'($urandom_range(0, 40) << 4);
    endfunction

    function automatic int rand_level();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 0;
        if (k == 1)
            return 16'hFFFF;
        if (k == 2)
            return $urandom() & 16'hFFFF;
        return $urandom_range(0, 40) << 4;
    endfunction

    // receiver: check at each edge, then pick the next ready
    initial begin
        edge_res_t want;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                if (edge_q.size() == 0) begin
                    report("unexpected result", out_ch.edge_value, -1);
                end
                else begin
                    want = edge_q.pop_front();
                    if (out_ch.edge_value !== want.val)
                        report("edge_value", out_ch.edge_value, want.val);
                    if (out_ch.frame_last !== want.last)
                        report("frame_last", out_ch.frame_last, want.last);
                end
                n_results++;
            end
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ch.ready <= rst_n && !(gaps_on && $urandom_range(0, 99) < 10);
        end
    end

    // watchdog on cycles with no request on either side
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("** canny_nms_hysteresis_top: FAILED **");
            $finish;
        end
    end

    initial begin
        bit got;
        int w, h, npix, phase;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_PIXEL;
        in_ch.magnitude = '0;
        in_ch.direction = '0;
        reg_w = RST_WIDTH;
        reg_h = RST_HEIGHT;
        reg_low = RST_LOW;
        reg_high = RST_HIGH;
        fw = 640;
        fh = 480;
        col_pos = 0;
        row_pos = 0;
        pend_cnt = 0;
        for (int i = 0; i < RING; i++)
        begin
            mag_ring[i] = '0;
            dir_ring[i] = '0;
            thin_ring[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == OP_CFG) begin
                write_reg(dir_tab[i].a, dir_tab[i].b);
            end
            else begin
                send_req(dir_tab[i].op == OP_FLUSH, MAG_W'(dir_tab[i].a),
                         DIR_W'(dir_tab[i].b), got);
                if (dir_tab[i].chk) begin
                    if (!got)
                        report("table row gave no result", i, 1);
                    else if (edge_q[edge_q.size() - 1].val !== dir_tab[i].ev
                             || edge_q[edge_q.size() - 1].last !== dir_tab[i].el)
                        report("table row", edge_q[edge_q.size() - 1].val, dir_tab[i].ev);
                end
            end
        end

        phase = 0;
        while (n_items < 1600 + 25) begin
            phase++;
            gaps_on = !(phase >= 20 && phase < 30);
            if (phase == 12) begin
                w = 4095;      // clamps to the widest row
                h = 1;
            end
            else begin
                w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
            end
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
            write_reg(CFG_LOW, rand_level());
            write_reg(CFG_HIGH, rand_level());
            if (phase == 5)
                hold_req = 1'b1;
            // one to three frames back to back
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0)
                    send_req(FUNC_FLUSH, MAG_W'($urandom()), DIR_W'($urandom()), got);
                npix = (w == 0 ? 1 : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w))
                       * (h == 0 ? 1 : h);
                for (int p = 0; p < npix; p++) begin
                    send_req(FUNC_PIXEL, rand_mag(), DIR_W'($urandom()), got);
                    if (p + 1 < npix && $urandom_range(0, 19) == 0)
                        send_req(FUNC_FLUSH, MAG_W'($urandom()), DIR_W'($urandom()), got);
                end
                while (!(row_pos == 0 && col_pos == 0))
                    send_req($urandom_range(0, 4) != 0, rand_mag(), DIR_W'($urandom()), got);
                n_frames++;
            end
        end

        in_ch.valid <= 1'b0;
        while (edge_q.size() != 0)
            @(posedge clk);
        repeat (2 * fw + 60) @(posedge clk);
        $display("covered %0d requests, %0d results over %0d random frames",
                 n_items, n_results, n_frames);
        $display("sizes up to the widest row, zero sizes, threshold extremes, back pressure");
        if (errors == 0)
            $display("** canny_nms_hysteresis_top: PASSED **");
        else
            $display("** canny_nms_hysteresis_top: FAILED **");
        $finish;
    end

endmodule
